[hw/rtl/av_timestamp_mix_queue_top_macros.svh]
// Assertion helpers for the mix queue RTL.
`ifndef AV_TIMESTAMP_MIX_QUEUE_TOP_MACROS_SVH
`define AV_TIMESTAMP_MIX_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define AVTSQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("avtsq assertion failed");
// Check an implication at every clock edge outside reset.
`define AVTSQ_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("avtsq assertion failed");
// Check a condition in the cycle after the trigger.
`define AVTSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("avtsq assertion failed");
`else
`define AVTSQ_ASSERT_ALWAYS(lbl, cond)
`define AVTSQ_ASSERT_IMPLY(lbl, ante, cons)
`define AVTSQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/avtsq_pkg.sv]
`timescale 1ns / 1ps

package avtsq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int THR_W = 4;
  localparam logic [THR_W-1:0] THR_RESET = 4'd10;

  typedef struct packed {
    logic [31:0] timestamp;
    logic        video;
    logic [15:0] tag;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] timestamp;
    logic        video;
    logic [15:0] tag;
  } out_beat_t;

  // Map a logical slot (0 = oldest/smallest) onto the circular store.
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[hw/rtl/av_timestamp_mix_queue_top.sv]
`timescale 1ns / 1ps
`include "av_timestamp_mix_queue_top_macros.svh"

// Timestamp-ordered audio/video mix queue. Pulse start with a message while
// busy is low; the block inserts it into a store sorted by timestamp (equal
// timestamps keep arrival order) and then, if the release rule allows,
// presents the smallest entry on out_data for exactly one cycle with
// out_valid high. The receiver cannot stall: sample out_data whenever
// out_valid is high. Release needs one audio and one video entry, or
// cfg threshold entries of one kind with the other kind absent. A message
// that arrives while the store holds DEPTH entries is dropped. After the
// accept edge, the insertion scan reads stored entries from the youngest
// downward, moving each larger one up a slot, and stops at the first entry
// that is not larger or after the oldest; an empty store skips the scan.
// The new entry is then written and the release rule is checked; a
// release reads the head entry and shows it as the beat. A dropped message
// skips the scan and the write. Each scanned entry takes a read state and a
// compare state because the store memory registers its read data. busy
// stays high from the accept edge until the beat (if any)
// has been shown. The threshold register may be written while busy is low.
module av_timestamp_mix_queue_top
  import avtsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_beat_t         in_data,
  output logic             out_valid,
  output out_beat_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_WNEW  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // Sorted store, kept as a circular buffer starting at head_r.
  out_beat_t mem [DEPTH];
  out_beat_t rd_q_r;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] vid_r, vid_nxt;
  logic [CNT_W-1:0] aud_r, aud_nxt;
  logic [THR_W-1:0] thr_r;
  in_beat_t         item_r, item_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  out_beat_t        wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic             release_ok;
  logic             full;

  assign full      = (occ_r == CNT_W'(DEPTH));
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = (state_r == S_EMIT);
  assign out_data  = rd_q_r;

  // Release rule, evaluated on the counts after the insertion.
  always_comb begin
    release_ok = 1'b0;
    if (occ_r != '0) begin
      if (vid_r != '0 && aud_r != '0) begin
        release_ok = 1'b1;
      end else if (32'(vid_r) >= 32'(thr_r) && aud_r == '0) begin
        release_ok = 1'b1;
      end else if (32'(aud_r) >= 32'(thr_r) && vid_r == '0) begin
        release_ok = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    idx_nxt   = idx_r;
    occ_nxt   = occ_r;
    vid_nxt   = vid_r;
    aud_nxt   = aud_r;
    item_nxt  = item_r;
    we        = 1'b0;
    waddr     = phys_addr(head_r, idx_r);
    wdata     = rd_q_r;
    re        = 1'b0;
    raddr     = phys_addr(head_r, idx_r);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          if (full) begin
            // Drop the message; still check for a release.
            state_nxt = S_CHECK;
          end else if (occ_r == '0) begin
            idx_nxt   = '0;
            state_nxt = S_WNEW;
          end else begin
            // Scan from the youngest (largest) entry downward.
            idx_nxt   = IDX_W'(occ_r - CNT_W'(1));
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        re        = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_q_r.timestamp > item_r.timestamp) begin
          // Move the larger entry up one slot.
          we    = 1'b1;
          waddr = phys_addr(head_r, IDX_W'(idx_r + IDX_W'(1)));
          wdata = rd_q_r;
          if (idx_r == '0) begin
            state_nxt = S_WNEW;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_WNEW;
        end
      end
      S_WNEW: begin
        we    = 1'b1;
        waddr = phys_addr(head_r, idx_r);
        wdata = out_beat_t'(item_r);
        occ_nxt = occ_r + CNT_W'(1);
        if (item_r.video) begin
          vid_nxt = vid_r + CNT_W'(1);
        end else begin
          aud_nxt = aud_r + CNT_W'(1);
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (release_ok) begin
          re        = 1'b1;
          raddr     = head_r;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // Advance past the released head entry.
        head_nxt = phys_addr(head_r, IDX_W'(1));
        occ_nxt  = occ_r - CNT_W'(1);
        if (rd_q_r.video) begin
          vid_nxt = vid_r - CNT_W'(1);
        end else begin
          aud_nxt = aud_r - CNT_W'(1);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      idx_r   <= '0;
      occ_r   <= '0;
      vid_r   <= '0;
      aud_r   <= '0;
      thr_r   <= THR_RESET;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      idx_r   <= idx_nxt;
      occ_r   <= occ_nxt;
      vid_r   <= vid_nxt;
      aud_r   <= aud_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  `AVTSQ_ASSERT_ALWAYS(a_count_sum, 32'(aud_r) + 32'(vid_r) == 32'(occ_r))
  `AVTSQ_ASSERT_ALWAYS(a_occ_bound, 32'(occ_r) <= DEPTH)
  `AVTSQ_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid && !busy)
  `AVTSQ_ASSERT_IMPLY(a_emit_after_check, out_valid, $past(state_r) == S_CHECK)
  `AVTSQ_ASSERT_NEXT(a_start_busy, start && !busy, busy)

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the audio/video mix queue. A predictor keeps its
// own sorted copy of the store and the kind counts, computes the release
// each accepted message causes, and queues it; a checker compares every
// out_valid beat with the oldest queued release.
module testbench;
  import avtsq_pkg::*;

  // Longest message: a scan past every stored entry plus a release.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int TIMEOUT_NS   = 2000000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_beat_t         in_data   = '0;
  logic             out_valid;
  out_beat_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data  = '0;

  av_timestamp_mix_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the sorted store, its fill level, the per-kind counts
  // and the threshold as last written.
  in_beat_t         mix_store [DEPTH];
  int               store_fill        = 0;
  int               video_held        = 0;
  int               audio_held        = 0;
  logic [THR_W-1:0] release_threshold = THR_RESET;

  // Releases predicted but not yet seen on the output, oldest first.
  out_beat_t pending_releases [$];
  int        fail_count = 0;

  // Random stimulus shaping: runs of one kind, and a drifting timestamp base
  // so that audio and video interleave the way real streams do.
  logic        burst_video = 1'b0;
  int          burst_left  = 0;
  logic [31:0] stream_base = '0;

  function automatic in_beat_t msg(input logic [31:0] ts, input logic vid,
                                   input logic [15:0] tag);
    in_beat_t m;
    m.timestamp = ts;
    m.video     = vid;
    m.tag       = tag;
    return m;
  endfunction

  // Insert one message (unless the store is full) behind all entries with an
  // equal or smaller timestamp, then release the head if the kind counts allow it.
  function void order_message(input in_beat_t m);
    int        pos;
    int        i;
    logic      allowed;
    out_beat_t head;
    if (store_fill < DEPTH) begin
      pos = 0;
      while (pos < store_fill && mix_store[pos].timestamp <= m.timestamp) pos++;
      for (i = store_fill; i > pos; i--) mix_store[i] = mix_store[i - 1];
      mix_store[pos] = m;
      store_fill++;
      if (m.video) video_held++;
      else audio_held++;
    end
    // A store that holds only one kind releases once that kind reaches the
    // threshold; any mix of both kinds releases at once.
    allowed = (store_fill != 0) &&
              ((video_held >= 1 && audio_held >= 1) ||
               (video_held >= int'(release_threshold) && audio_held == 0) ||
               (audio_held >= int'(release_threshold) && video_held == 0));
    if (allowed) begin
      head.timestamp = mix_store[0].timestamp;
      head.video     = mix_store[0].video;
      head.tag       = mix_store[0].tag;
      pending_releases = {pending_releases, head};
      if (head.video) video_held--;
      else audio_held--;
      for (i = 1; i < store_fill; i++) mix_store[i - 1] = mix_store[i];
      store_fill--;
    end
  endfunction

  function in_beat_t random_message();
    int          pick;
    logic [31:0] ts;
    if (burst_left == 0) begin
      burst_video = 1'($urandom_range(0, 1));
      // Mostly short runs keep both kinds present; long runs of one kind
      // push the store up against the threshold.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                               : $urandom_range(1, 3);
    end
    burst_left--;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      ts = $urandom();
    end else if (pick < 4) begin
      // Tiny range: plenty of equal timestamps to test arrival order.
      ts = 32'($urandom_range(0, 7));
    end else if (pick == 4) begin
      ts = 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
    end else begin
      stream_base = stream_base + 32'($urandom_range(0, 40));
      ts = stream_base + 32'($urandom_range(0, 30));
    end
    return msg(ts, burst_video, 16'($urandom()));
  endfunction

  // Present one message and hold it until the block takes it. Before that,
  // drop start for a random number of cycles, each idle with idle_pct
  // percent chance. Start stays high on return so the next message can
  // follow without a gap; whoever stops sending lowers it.
  task send_message(input in_beat_t m, input int idle_pct);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= m;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    order_message(m);
  endtask

  // Stop sending, wait for every predicted release, then give a message
  // that releases nothing time to finish its scan.
  task drain_block();
    start <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_threshold(input logic [THR_W-1:0] value);
    drain_block();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    release_threshold = value;
  endtask

  // Reset threshold, field extremes, and equal timestamps that must leave
  // in arrival order, within one kind and across kinds.
  task test_sort_order();
    send_message(msg(32'hFFFF_FFFF, 1'b0, 16'hFFFF), 0);
    send_message(msg(32'h0000_0000, 1'b0, 16'h0000), 0);
    send_message(msg(32'h0000_0000, 1'b0, 16'h0001), 0);
    // First video beat: both kinds present, the oldest zero leaves.
    send_message(msg(32'h0000_0000, 1'b1, 16'h0002), 0);
    send_message(msg(32'h0000_0000, 1'b1, 16'h0003), 0);
    send_message(msg(32'hFFFF_FFFF, 1'b1, 16'h0004), 0);
    send_message(msg(32'h8000_0000, 1'b0, 16'h8000), 0);
  endtask

  // Threshold zero: a store of one kind releases on every message. Purge
  // the audio entries first so the store really holds one kind.
  task test_threshold_zero();
    write_threshold(4'd0);
    send_message(msg(32'h0000_0001, 1'b0, 16'h0005), 0);
    send_message(msg(32'hFFFF_FFFF, 1'b1, 16'h0006), 0);
    send_message(msg(32'hFFFF_FFFF, 1'b1, 16'h0007), 0);
    send_message(msg(32'h7FFF_FFFF, 1'b1, 16'h7FFF), 0);
  endtask

  // One kind below the threshold holds; reaching it releases; the other
  // kind arriving releases at once.
  task test_threshold_mid();
    write_threshold(4'd5);
    send_message(msg(32'h1234_5678, 1'b1, 16'h1234), 0);
    send_message(msg(32'hEDCB_A987, 1'b1, 16'hEDCB), 0);
    send_message(msg(32'hFFFF_FFFE, 1'b0, 16'hAAAA), 0);
  endtask

  task test_random_mix(input logic [THR_W-1:0] thr, input int idle_pct,
                       input int count);
    int n;
    write_threshold(thr);
    for (n = 0; n < count; n++) send_message(random_message(), idle_pct);
  endtask

  // Compare each out_valid beat with the oldest predicted release. The
  // receiver cannot stall, so every beat is taken at the edge it is shown.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_releases.size() == 0) begin
        $error("out beat with nothing pending: timestamp %h tag %h",
               out_data.timestamp, out_data.tag);
        fail_count++;
      end else begin
        want = pending_releases.pop_front();
        if (out_data.timestamp !== want.timestamp) begin
          $error("out_timestamp: expected %h, got %h", want.timestamp,
                 out_data.timestamp);
          fail_count++;
        end
        if (out_data.video !== want.video) begin
          $error("out_video: expected %b, got %b", want.video,
                 out_data.video);
          fail_count++;
        end
        if (out_data.tag !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, out_data.tag);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_sort_order();
    test_threshold_zero();
    test_threshold_mid();
    // Low thresholds first: the store only grows, so keep it small while
    // the pure-kind rule still matters, and open up to the maximum later.
    test_random_mix(4'd1, 0, 250);
    test_random_mix(4'd7, 70, 250);
    test_random_mix(4'd15, 21, 250);
    test_random_mix(4'd0, 0, 250);
    drain_block();
    if (pending_releases.size() != 0) begin
      $error("releases never seen: %0d", pending_releases.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs with busy high.
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
